@@ rtl/ppr_pkg.sv @@
`timescale 1ns / 1ps

package ppr_pkg;

  localparam int RANK_W  = 26;
  localparam int FIELDS  = 7;
  localparam int COUNT_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd7;

endpackage

@@ rtl/ppr_cell.sv @@
`timescale 1ns / 1ps

module ppr_cell #(
  parameter int IDX         = 0,
  parameter int BOARD_CELLS = 16,
  parameter int PW          = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ppr_pkg::COUNT_W-1:0]         in_count,
  input  logic [ppr_pkg::FIELDS*PW-1:0]       in_pos,
  input  logic [ppr_pkg::RANK_W-1:0]          in_acc,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ppr_pkg::COUNT_W-1:0]         out_count,
  output logic [ppr_pkg::FIELDS*PW-1:0]       out_pos,
  output logic [ppr_pkg::RANK_W-1:0]          out_acc
);
  import ppr_pkg::*;

  localparam int SM_W = $clog2(FIELDS + 1);
  // radix of this digit, wrapped like the unsigned weight product
  localparam logic [RANK_W-1:0] RADIX = RANK_W'(BOARD_CELLS - IDX);

  logic [SM_W-1:0]   smaller;
  logic [PW-1:0]     own;
  logic [RANK_W-1:0] digit;
  logic [RANK_W-1:0] acc_next;
  logic              active;

  assign own      = in_pos[IDX*PW +: PW];
  assign in_ready = !out_valid || out_ready;
  assign active   = int'(in_count) > IDX;

  always_comb begin
    smaller = '0;
    for (int j = 0; j < IDX; j++) begin
      if (in_pos[j*PW +: PW] < own) smaller = smaller + SM_W'(1);
    end
  end

  // digit may go negative with duplicate cells, sum wraps
  assign digit    = RANK_W'(own) - RANK_W'(smaller);
  assign acc_next = active ? RANK_W'(in_acc * RADIX) + digit : in_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_count <= in_count;
      out_pos   <= in_pos;
      out_acc   <= acc_next;
    end
  end

endmodule

@@ rtl/partial_permutation_rank.sv @@
`timescale 1ns / 1ps

// ranks an ordered tuple of up to seven distinct board cells as a partial
// permutation, giving the address of a pattern-database entry
// request channel: item_valid / item_ready with pos_0 .. pos_6, pos_0 the
// most significant digit; result channel: rank_valid / rank_ready with rank
// config channel: cfg_valid / cfg_ready with piece_count, always ready; only
// the first piece_count cells take part (0 gives rank 0, capped at seven)
// a row of cells, one per digit, each reducing its cell by the earlier
// smaller ones and folding it into the running rank by horner's rule
// one registered stage per cell between request and rank; throughput one
// request per cycle while rank_ready stays high
// each cell stage has its own valid bit and register, so a stalled receiver
// backs up the row one stage at a time and requests are still taken while
// empty stages remain
// reset empties every stage and sets piece_count to 7
module partial_permutation_rank #(
  parameter int MAX_PIECES  = 7,
  parameter int BOARD_CELLS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppr_pkg::COUNT_W-1:0]       piece_count,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [$clog2(BOARD_CELLS)-1:0]    pos_0,
  input  logic [$clog2(BOARD_CELLS)-1:0]    pos_1,
  input  logic [$clog2(BOARD_CELLS)-1:0]    pos_2,
  input  logic [$clog2(BOARD_CELLS)-1:0]    pos_3,
  input  logic [$clog2(BOARD_CELLS)-1:0]    pos_4,
  input  logic [$clog2(BOARD_CELLS)-1:0]    pos_5,
  input  logic [$clog2(BOARD_CELLS)-1:0]    pos_6,
  output logic                              rank_valid,
  input  logic                              rank_ready,
  output logic [ppr_pkg::RANK_W-1:0]        rank
);
  import ppr_pkg::*;

  localparam int PW     = $clog2(BOARD_CELLS);
  localparam int NCELLS = (MAX_PIECES < FIELDS) ? MAX_PIECES : FIELDS;

  logic [COUNT_W-1:0] pieces;

  logic                     stg_valid [NCELLS+1];
  logic                     stg_ready [NCELLS+1];
  logic [COUNT_W-1:0]       stg_count [NCELLS+1];
  logic [FIELDS*PW-1:0]     stg_pos   [NCELLS+1];
  logic [RANK_W-1:0]        stg_acc   [NCELLS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pieces <= COUNT_RESET;
    end else if (cfg_valid) begin
      pieces <= piece_count;
    end
  end

  assign stg_valid[0] = item_valid;
  assign item_ready   = stg_ready[0];
  assign stg_count[0] = pieces;
  assign stg_pos[0]   = {pos_6, pos_5, pos_4, pos_3, pos_2, pos_1, pos_0};
  assign stg_acc[0]   = '0;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    ppr_cell #(
      .IDX         (i),
      .BOARD_CELLS (BOARD_CELLS),
      .PW          (PW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_count  (stg_count[i]),
      .in_pos    (stg_pos[i]),
      .in_acc    (stg_acc[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_count (stg_count[i+1]),
      .out_pos   (stg_pos[i+1]),
      .out_acc   (stg_acc[i+1])
    );
  end

  assign stg_ready[NCELLS] = rank_ready;
  assign rank_valid        = stg_valid[NCELLS];
  assign rank              = stg_acc[NCELLS];

endmodule

@@ rtl/ppr_checker.sv @@
`timescale 1ns / 1ps

module ppr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic                       rank_valid,
  input logic                       rank_ready,
  input logic [ppr_pkg::RANK_W-1:0] rank
);
  import ppr_pkg::*;

  // a stalled rank holds
  assert property (@(posedge clk) disable iff (rst)
    rank_valid && !rank_ready |=> rank_valid && $stable(rank))
    else $error("rank changed or dropped while stalled");

  // the row is empty right after reset
  assert property (@(posedge clk) rst |=> !rank_valid && item_ready)
    else $error("row not empty after reset");

  // requests are refused only when the row is full up to a stalled output
  assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> rank_valid && !rank_ready)
    else $error("request refused without back pressure");

  // a request is taken whenever the output holds no rank
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !rank_valid |-> item_ready)
    else $error("request refused with empty output");

endmodule

bind partial_permutation_rank ppr_checker u_ppr_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_ready (item_ready),
  .rank_valid (rank_valid),
  .rank_ready (rank_ready),
  .rank       (rank)
);

@@ bench/partial_permutation_rank_test.sv @@
`timescale 1ns / 1ps

module partial_permutation_rank_test;

  localparam int CELL_W = 4;
  localparam int CELLS  = 16;
  localparam int PER_PHASE = 88;

  typedef logic [ppr_pkg::FIELDS-1:0][CELL_W-1:0] cells_t;
  typedef logic [ppr_pkg::RANK_W-1:0] rank_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ppr_pkg::COUNT_W-1:0] count_wr = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  cells_t cells_drv = '0;
  logic rank_valid;
  logic rank_ready = 1'b0;
  rank_t rank;

  cells_t pending_q[$];
  rank_t rank_q[$];
  int pushed = 0;
  int accepted = 0;
  int checked = 0;
  int errors = 0;
  int gap_left = 0;
  int stall_left = 0;
  int send_calm = 0;
  int recv_calm = 0;
  logic [ppr_pkg::COUNT_W-1:0] count_cfg = ppr_pkg::COUNT_RESET;

  partial_permutation_rank i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .piece_count(count_wr),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .pos_0      (cells_drv[0]),
    .pos_1      (cells_drv[1]),
    .pos_2      (cells_drv[2]),
    .pos_3      (cells_drv[3]),
    .pos_4      (cells_drv[4]),
    .pos_5      (cells_drv[5]),
    .pos_6      (cells_drv[6]),
    .rank_valid (rank_valid),
    .rank_ready (rank_ready),
    .rank       (rank)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mixed-radix rank of the first count cells, wrapped to the rank width
  function automatic rank_t rank_of(input cells_t cells, input int unsigned count);
    int unsigned n;
    int unsigned sum;
    int unsigned below;
    int unsigned radix;
    n = (count > ppr_pkg::FIELDS) ? ppr_pkg::FIELDS : count;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      below = 0;
      for (int j = 0; j < i; j++)
        if (cells[j] < cells[i]) below++;
      radix = 1;
      for (int k = i + 1; k < n; k++)
        radix *= CELLS - k;
      sum += (int'(cells[i]) - below) * radix;
    end
    return sum[ppr_pkg::RANK_W-1:0];
  endfunction

  // random wait after each request or result, with runs of back-to-back traffic now and then
  function automatic int pace(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 13);
  endfunction

  // mostly distinct cells (a real partial permutation), some raw noise
  function automatic cells_t random_board();
    int pool[CELLS];
    int pick;
    int tmp;
    cells_t cells;
    if ($urandom_range(0, 3) == 0) begin
      cells = cells_t'($urandom);
      return cells;
    end
    for (int k = 0; k < CELLS; k++) pool[k] = k;
    for (int k = CELLS - 1; k > 0; k--) begin
      pick = $urandom_range(0, k);
      tmp = pool[k];
      pool[k] = pool[pick];
      pool[pick] = tmp;
    end
    for (int k = 0; k < ppr_pkg::FIELDS; k++) cells[k] = CELL_W'(pool[k]);
    return cells;
  endfunction

  task automatic push_board(input cells_t cells);
    pending_q.insert(pending_q.size(), cells);
    pushed++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (accepted != pushed || checked != accepted);
  endtask

  task automatic write_count(input int unsigned value);
    cfg_valid <= 1'b1;
    count_wr <= value[ppr_pkg::COUNT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left <= 0;
    end else if (item_valid && !item_ready) begin
      // hold the request until taken
    end else if (gap_left > 0) begin
      item_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_q.size() != 0) begin
      cells_drv <= pending_q.pop_front();
      item_valid <= 1'b1;
      gap_left <= pace(send_calm);
    end else begin
      item_valid <= 1'b0;
    end
  end

  // predictor, result checker and receiver stalls
  always @(posedge clk) begin
    rank_t want;
    int stall;
    if (rst) begin
      rank_ready <= 1'b0;
      stall_left <= 0;
      count_cfg = ppr_pkg::COUNT_RESET;
    end else begin
      if (item_valid && item_ready) begin
        rank_q.insert(rank_q.size(), rank_of(cells_drv, count_cfg));
        accepted++;
      end
      if (cfg_valid && cfg_ready) count_cfg = count_wr;
      if (rank_valid && rank_ready) begin
        if (rank_q.size() == 0) begin
          $display("%0t unexpected rank: expected none actual %0d", $time, rank);
          errors++;
        end else begin
          want = rank_q.pop_front();
          checked++;
          if (rank !== want) begin
            $display("%0t rank mismatch: expected %0d actual %0d", $time, want, rank);
            errors++;
          end
        end
        stall = pace(recv_calm);
        stall_left <= stall;
        rank_ready <= (stall == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rank_ready <= (stall_left == 1);
      end else begin
        rank_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned plan[12];
    plan = '{0, 1, 7, 4, 2, 6, 3, 5, 7, 1, 0, 7};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset count of seven: edges, ordered runs and repeated cells
    push_board(28'h0000000);
    push_board(28'hFFFFFFF);
    push_board(28'h6543210);
    push_board(28'h9ABCDEF);
    push_board(28'h0123456);
    push_board(28'hFEDCBA9);
    push_board(28'h4321000);
    push_board(28'h5A5A5A5);
    push_board(28'hA5A5A5A);
    push_board(28'h3D2E1F0);
    push_board(28'h1111110);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      write_count(plan[p]);
      if (plan[p] == 0) begin
        push_board(28'hFFFFFFF);
        push_board(28'h9ABCDEF);
      end
      for (int k = 0; k < PER_PHASE; k++) push_board(random_board());
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
